@@ sv/daq_pkg.sv @@
package daq_pkg;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned PAYLOAD_BITS = 32;

  // count must hold QUEUE_DEPTH itself
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_TAKE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_EXPIRED = 3'd2,
    KIND_READY   = 3'd3,
    KIND_NONE    = 3'd4,
    KIND_DONE    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [31:0]             expiry;
    logic [31:0]             start;
    logic                    has_side;
    logic                    side;
  } entry_t;

  // per-cell control: load from insert bus wins over shift from neighbor
  typedef struct packed {
    logic ld;
    logic shift;
  } cell_ctl_t;

endpackage

@@ sv/daq_cell.sv @@
module daq_cell (
  input  logic               clk_i,
  input  daq_pkg::cell_ctl_t ctl_i,
  input  daq_pkg::entry_t    nxt_i,
  input  daq_pkg::entry_t    ins_i,
  output daq_pkg::entry_t    ent_o
);

  daq_pkg::entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld) begin
      ent_q <= ins_i;
    end else if (ctl_i.shift) begin
      ent_q <= nxt_i;
    end
  end

  assign ent_o = ent_q;

endmodule

@@ sv/deadline_action_queue_unit.sv @@
// Enqueue and clear: one result word, registered, valid the cycle after accept.
// Remove-side and take: the queue is rotated through the cell chain one entry
// per cycle, but a take holds on an entry it must emit while the output stalls;
// the next word is accepted once all entries are rotated; take emits as it goes.
// Reset (rst_ni low, async): entry count and output valid cleared, queue empty.
// Cell contents are not reset; only entries below the count are ever read.
module deadline_action_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] now_tick_i,
  input  logic [31:0] payload_i,
  input  logic [31:0] expiry_tick_i,
  input  logic [31:0] start_tick_i,
  input  logic        has_side_i,
  input  logic        side_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] out_payload_o,
  output logic [31:0] out_expiry_o,
  output logic [31:0] out_start_o,
  output logic        out_has_side_o,
  output logic        out_side_o,
  output logic        last_o
);

  localparam int unsigned DEPTH = daq_pkg::QUEUE_DEPTH;
  localparam int unsigned CW    = daq_pkg::CNT_W;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  daq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;     // entries stored
  logic [CW-1:0]   rem_q, rem_d;     // entries still to rotate past the head
  daq_pkg::op_e    op_q;
  logic [31:0]     now_q;
  logic            side_q;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the head (oldest). On a rotate every cell takes its
  // upper neighbor; a kept head is written back at the tail (cnt - 1).
  // ---------------------------------------------------------------------------
  daq_pkg::entry_t    ent    [DEPTH];
  daq_pkg::cell_ctl_t ctl    [DEPTH];
  daq_pkg::entry_t    ins_ent;
  daq_pkg::entry_t    in_ent;
  daq_pkg::entry_t    head;
  daq_pkg::entry_t    zero_ent;

  logic          wr_en;
  logic          wr_head;      // write-back source: head (rotate) or input (enqueue)
  logic [CW-1:0] wr_pos;
  logic          rotate;
  logic          keep;

  assign zero_ent = '0;
  assign head     = ent[0];

  always_comb begin
    in_ent          = '0;
    in_ent.payload  = daq_pkg::PAYLOAD_BITS'(payload_i);
    in_ent.expiry   = expiry_tick_i;
    in_ent.start    = start_tick_i;
    in_ent.has_side = has_side_i;
    in_ent.side     = side_i;
  end

  assign ins_ent = wr_head ? head : in_ent;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].ld    = wr_en && (wr_pos == CW'(i));
      ctl[i].shift = rotate;
    end

    if (i == DEPTH - 1) begin : g_tail
      daq_cell u_cell (
        .clk_i (clk_i),
        .ctl_i (ctl[i]),
        .nxt_i (zero_ent),
        .ins_i (ins_ent),
        .ent_o (ent[i])
      );
    end else begin : g_body
      daq_cell u_cell (
        .clk_i (clk_i),
        .ctl_i (ctl[i]),
        .nxt_i (ent[i+1]),
        .ins_i (ins_ent),
        .ent_o (ent[i])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Head checks, wraparound compare by sign of the 32-bit difference
  // ---------------------------------------------------------------------------
  logic [31:0] diff_ex;
  logic [31:0] diff_st;
  logic        head_expired;
  logic        head_deferred;
  logic        head_match;

  assign diff_ex       = head.expiry - now_q;
  assign diff_st       = now_q - head.start;
  assign head_expired  = (head.expiry != 32'd0) && diff_ex[31];
  assign head_deferred = (head.start != 32'd0) && diff_st[31];
  assign head_match    = head.has_side && (head.side == side_q);

  // ---------------------------------------------------------------------------
  // Output register and handshake
  // ---------------------------------------------------------------------------
  logic            out_valid_q;
  logic            can_emit;
  logic            in_acc;
  logic            scan_end;
  logic            scan_hit;

  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == daq_pkg::ST_IDLE) && can_emit;
  assign in_acc     = in_valid_i && in_ready_o;

  // scan finished: closing word goes out
  assign scan_end = (rem_q == '0) && can_emit;
  // take found a ready entry at the head
  assign scan_hit = (rem_q != '0) && (op_q == daq_pkg::OP_TAKE) && !head_expired
                    && !head_deferred && can_emit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      daq_pkg::ST_IDLE: begin
        if (in_acc && ((daq_pkg::op_e'(op_i) == daq_pkg::OP_REMOVE) ||
                       (daq_pkg::op_e'(op_i) == daq_pkg::OP_TAKE))) begin
          state_d = daq_pkg::ST_SCAN;
        end
      end
      daq_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = daq_pkg::ST_IDLE;
        end else if (scan_hit) begin
          state_d = daq_pkg::ST_DRAIN;
        end
      end
      daq_pkg::ST_DRAIN: begin
        if (rem_q == '0) begin
          state_d = daq_pkg::ST_IDLE;
        end
      end
      default: state_d = daq_pkg::ST_IDLE;
    endcase
  end

  // datapath control and emitted word
  logic          emit;
  daq_pkg::kind_e emit_kind;
  logic          emit_ent;
  logic          emit_last;

  always_comb begin
    emit      = 1'b0;
    emit_kind = daq_pkg::KIND_DONE;
    emit_ent  = 1'b0;
    emit_last = 1'b0;
    rotate    = 1'b0;
    keep      = 1'b0;
    wr_en     = 1'b0;
    wr_head   = 1'b0;
    wr_pos    = cnt_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;

    unique case (state_q)
      daq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (daq_pkg::op_e'(op_i))
            daq_pkg::OP_ENQUEUE: begin
              emit      = 1'b1;
              emit_last = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                emit_kind = daq_pkg::KIND_FULL;
              end else begin
                emit_kind = daq_pkg::KIND_ACCEPT;
                wr_en     = 1'b1;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            daq_pkg::OP_REMOVE,
            daq_pkg::OP_TAKE: begin
              rem_d = cnt_q;
            end
            daq_pkg::OP_CLEAR: begin
              emit      = 1'b1;
              emit_last = 1'b1;
              emit_kind = daq_pkg::KIND_DONE;
              cnt_d     = '0;
            end
          endcase
        end
      end

      daq_pkg::ST_SCAN: begin
        if (rem_q == '0) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_kind = (op_q == daq_pkg::OP_TAKE) ? daq_pkg::KIND_NONE
                                                   : daq_pkg::KIND_DONE;
          end
        end else if (op_q == daq_pkg::OP_TAKE) begin
          if (head_expired) begin
            if (can_emit) begin
              emit      = 1'b1;
              emit_kind = daq_pkg::KIND_EXPIRED;
              emit_ent  = 1'b1;
              rotate    = 1'b1;
            end
          end else if (!head_deferred) begin
            if (can_emit) begin
              emit      = 1'b1;
              emit_kind = daq_pkg::KIND_READY;
              emit_ent  = 1'b1;
              emit_last = 1'b1;
              rotate    = 1'b1;
            end
          end else begin
            rotate = 1'b1;
            keep   = 1'b1;
          end
        end else begin
          // remove by side: drop matching entries, never emits mid-scan
          rotate = 1'b1;
          keep   = !head_match;
        end
      end

      daq_pkg::ST_DRAIN: begin
        // restore order of the entries behind the taken one
        if (rem_q != '0) begin
          rotate = 1'b1;
          keep   = 1'b1;
        end
      end

      default: ;
    endcase

    if (rotate) begin
      rem_d = rem_q - 1'b1;
      if (keep) begin
        wr_en   = 1'b1;
        wr_head = 1'b1;
        wr_pos  = cnt_q - 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= daq_pkg::ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  daq_pkg::kind_e  kind_q;
  daq_pkg::entry_t out_ent_q;
  logic            last_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= daq_pkg::op_e'(op_i);
      now_q  <= now_tick_i;
      side_q <= side_i;
    end
    if (emit) begin
      kind_q    <= emit_kind;
      out_ent_q <= emit_ent ? head : zero_ent;
      last_q    <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_payload_o  = 32'(out_ent_q.payload);
  assign out_expiry_o   = out_ent_q.expiry;
  assign out_start_o    = out_ent_q.start;
  assign out_has_side_o = out_ent_q.has_side;
  assign out_side_o     = out_ent_q.side;
  assign last_o         = last_q;

endmodule
